// File: sv/hrm_pkg.sv
// ----------------------------------------------------------------------------
// hrm_pkg
// shared constants and types for the gray-level histogram engine
// ----------------------------------------------------------------------------
`default_nettype none
package hrm_pkg;
    localparam int BINS        = 256;
    localparam int COUNT_WIDTH = 24;
    localparam int BIN_W       = $clog2(BINS);
    localparam int DIV_W       = COUNT_WIDTH + 16;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [7:0]  BAR_FULL = 8'd250;
    localparam logic [14:0] PCT_FULL = 15'd25600;

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [0:0] CFG_RANGE_LOW  = 1'd0;
    localparam logic [0:0] CFG_RANGE_HIGH = 1'd1;

    typedef struct packed {
        logic                   start;
        logic [DIV_W-1:0]       dividend;
        logic [COUNT_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [BIN_W-1:0] clamp_bin(input logic [7:0] v);
        if (BINS >= 256)
            return BIN_W'(v);
        else if (32'(v) >= BINS)
            return BIN_W'(BINS - 1);
        else
            return BIN_W'(v);
    endfunction
endpackage
`default_nettype wire

// File: sv/hrm_ram.sv
// ----------------------------------------------------------------------------
// hrm_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module hrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: sv/hrm_div.sv
// ----------------------------------------------------------------------------
// hrm_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module hrm_div
    import hrm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]       quot_reg, quot_next;
    logic [COUNT_WIDTH:0]   rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [COUNT_WIDTH:0]   trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[COUNT_WIDTH-1:0], quot_reg[DIV_W-1]};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = trial - {1'b0, dvs_reg};
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;
endmodule
`default_nettype wire

// File: sv/histogram_range_max_engine_unit.sv
// ----------------------------------------------------------------------------
// histogram_range_max_engine_unit
// 256-bin gray-level histogram with range maximum, bin query and clear
// ----------------------------------------------------------------------------
// usage
//   s_axis beat: tdata = pixel_value, query_bin; tuser = kind
//     kind 0 pixel, 1 finish (range max), 2 query, 3 clear
//   m_axis beat: one per finish or query, none for pixel or clear
//   cfg_we/cfg_addr/cfg_wdata: register 0 range_low, 1 range_high; write
//     only while idle; reversed limits are used swapped
// sequencing, from the accepting cycle until another beat can be taken
//   a single sequencer drives one ram port and one shared divider
//   pixel: accept, read, then saturating add and write back
//   finish: scans the range from lo to hi, one bin compared per cycle
//   query: read the bin, then bar and percent share the 40-step divider;
//     a division is skipped when the maximum or the total is zero
//   clear: one bin zeroed per cycle, over all bins
//   reset starts a clearing pass over all bins, no beat taken meanwhile
// stall
//   a result waits in the output register; a new beat is taken at once,
//   but another result is held back until the old one has left
// ----------------------------------------------------------------------------
`default_nettype none
module histogram_range_max_engine_unit
    import hrm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // pixel_value[7:0], query_bin[15:8]
    input  wire logic [1:0]  s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // range_max[23:0], bin_count[47:24], bar_height[55:48], percent_q8[70:56],
    // in_range[71], pixel_total[95:72]
    output logic [95:0]      m_axis_tdata,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);
    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_PRD    = 4'd2;
    localparam logic [3:0] ST_PWR    = 4'd3;
    localparam logic [3:0] ST_FSCAN  = 4'd4;
    localparam logic [3:0] ST_QRD    = 4'd5;
    localparam logic [3:0] ST_QBAR   = 4'd6;
    localparam logic [3:0] ST_QPCT   = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;
    localparam logic [3:0] ST_FEMIT  = 4'd9;
    localparam logic [3:0] ST_QWAIT  = 4'd10;

    logic [3:0]             state_reg, state_next;
    logic [BIN_W-1:0]       addr_reg, addr_next;
    logic [BIN_W:0]         left_reg, left_next;   // bins still to fetch in a scan
    logic                   cmp_reg, cmp_next;      // ram data valid for compare
    logic                   last_reg, last_next;
    logic [7:0]             lo_cfg_reg, hi_cfg_reg;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic [COUNT_WIDTH-1:0] max_reg, max_next;
    logic [COUNT_WIDTH-1:0] scan_reg, scan_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [7:0]             bar_reg, bar_next;
    logic                   inr_reg, inr_next;
    logic                   ovalid_reg, ovalid_next;
    logic [95:0]            odata_reg, odata_next;

    logic                   ram_we;
    logic [BIN_W-1:0]       ram_addr;
    logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;
    div_req_t               dreq;
    div_rsp_t               drsp;
    logic [BIN_W-1:0]       lim_a, lim_b, lim_lo, lim_hi;
    logic [BIN_W-1:0]       qbin;
    logic                   take;

    hrm_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BINS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    hrm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // limits, clamped and ordered
    assign lim_a  = clamp_bin(lo_cfg_reg);
    assign lim_b  = clamp_bin(hi_cfg_reg);
    assign lim_lo = (lim_a > lim_b) ? lim_b : lim_a;
    assign lim_hi = (lim_a > lim_b) ? lim_a : lim_b;
    assign qbin   = clamp_bin(s_axis_tdata[15:8]);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign take          = s_axis_tvalid && s_axis_tready;
    assign ram_addr      = addr_reg;

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        left_next   = left_reg;
        cmp_next    = 1'b0;
        last_next   = last_reg;
        total_next  = total_reg;
        max_next    = max_reg;
        scan_next   = scan_reg;
        cnt_next    = cnt_reg;
        bar_next    = bar_reg;
        inr_next    = inr_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        odata_next  = odata_reg;
        ram_we      = 1'b0;
        ram_wdata   = '0;
        dreq        = '0;

        case (state_reg)
            ST_INIT:
            begin
                // clearing pass, also used by clear beats
                ram_we    = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == BIN_W'(BINS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    case (s_axis_tuser)
                        KIND_PIXEL:
                        begin
                            addr_next  = clamp_bin(s_axis_tdata[7:0]);
                            state_next = ST_PRD;
                        end
                        KIND_FINISH:
                        begin
                            addr_next  = lim_lo;
                            left_next  = {1'b0, lim_hi} - {1'b0, lim_lo} + 1'b1;
                            scan_next  = '0;
                            state_next = ST_FSCAN;
                        end
                        KIND_QUERY:
                        begin
                            addr_next  = qbin;
                            inr_next   = (qbin >= lim_lo) && (qbin <= lim_hi);
                            state_next = ST_QRD;
                        end
                        KIND_CLEAR:
                        begin
                            addr_next  = '0;
                            total_next = '0;
                            max_next   = '0;
                            state_next = ST_INIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PRD:
            begin
                state_next = ST_PWR;
                if (total_reg != COUNT_MAX)
                    total_next = total_reg + 1'b1;
            end
            ST_PWR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
                state_next = ST_IDLE;
            end
            ST_FSCAN:
            begin
                // fetch one bin a cycle, compare the one read last cycle
                if (cmp_reg && ram_rdata > scan_reg)
                    scan_next = ram_rdata;
                if (left_reg != '0)
                begin
                    cmp_next  = 1'b1;
                    left_next = left_reg - 1'b1;
                    if (left_reg != (BIN_W+1)'(1))
                        addr_next = addr_reg + 1'b1;
                end
                else if (!cmp_reg)
                    state_next = ST_FEMIT;
            end
            ST_FEMIT:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    max_next    = scan_reg;
                    ovalid_next = 1'b1;
                    odata_next  = {total_reg, 1'b0, 15'd0, 8'd0,
                                   {COUNT_WIDTH{1'b0}}, scan_reg};
                    state_next  = ST_IDLE;
                end
            end
            ST_QRD:
            begin
                state_next = ST_QWAIT;
            end
            ST_QWAIT:
            begin
                cnt_next   = ram_rdata;
                bar_next   = '0;
                if (max_reg != '0)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = DIV_W'(ram_rdata) * DIV_W'(BAR_FULL);
                    dreq.divisor  = max_reg;
                    state_next    = ST_QBAR;
                end
                else
                begin
                    last_next  = 1'b0;
                    state_next = ST_QPCT;
                end
            end
            ST_QBAR:
            begin
                if (drsp.done)
                begin
                    bar_next = (drsp.quotient > DIV_W'(BAR_FULL)) ? BAR_FULL
                                                                  : drsp.quotient[7:0];
                    last_next  = 1'b0;
                    state_next = ST_QPCT;
                end
            end
            ST_QPCT:
            begin
                if (!last_reg)
                begin
                    last_next = 1'b1;
                    if (total_reg != '0)
                    begin
                        dreq.start    = 1'b1;
                        dreq.dividend = DIV_W'(cnt_reg) * DIV_W'(PCT_FULL);
                        dreq.divisor  = total_reg;
                    end
                end
                else if (!drsp.busy && !dreq.start)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next[23:0]  = max_reg;
                    odata_next[47:24] = cnt_reg;
                    odata_next[55:48] = bar_reg;
                    if (total_reg == '0)
                        odata_next[70:56] = '0;
                    else if (drsp.quotient > DIV_W'(PCT_FULL))
                        odata_next[70:56] = PCT_FULL;
                    else
                        odata_next[70:56] = drsp.quotient[14:0];
                    odata_next[71]    = inr_reg;
                    odata_next[95:72] = total_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            addr_reg   <= '0;
            left_reg   <= '0;
            cmp_reg    <= 1'b0;
            last_reg   <= 1'b0;
            total_reg  <= '0;
            max_reg    <= '0;
            ovalid_reg <= 1'b0;
            lo_cfg_reg <= 8'd0;
            hi_cfg_reg <= 8'd255;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            left_reg   <= left_next;
            cmp_reg    <= cmp_next;
            last_reg   <= last_next;
            total_reg  <= total_next;
            max_reg    <= max_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we && cfg_addr == CFG_RANGE_LOW)
                lo_cfg_reg <= cfg_wdata;
            if (cfg_we && cfg_addr == CFG_RANGE_HIGH)
                hi_cfg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg  <= scan_next;
        cnt_reg   <= cnt_next;
        bar_reg   <= bar_next;
        inr_reg   <= inr_next;
        odata_reg <= odata_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
endmodule
`default_nettype wire

// File: sv/hrm_checker.sv
// ----------------------------------------------------------------------------
// hrm_checker
// port-level checks for the histogram engine
// ----------------------------------------------------------------------------
`default_nettype none
module hrm_checker
    import hrm_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [95:0] m_axis_tdata
);
    // a held result does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // bar height never above full scale
    a_bar: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:48] <= BAR_FULL)
        else $error("bar height above 250");

    // percent never above 100
    a_pct: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[70:56] <= PCT_FULL)
        else $error("percent above 100");

    // sequential engine: not ready the cycle after taking a beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("beat taken back to back");

    // pixel beats never produce a result the next cycle from nothing
    a_pix: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_PIXEL && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("result from pixel beat");
endmodule

bind histogram_range_max_engine_unit hrm_checker u_hrm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
